// ===== rtl/core/cfa_pkg.sv =====
// Shared types, codes and default sizes for the contiguous fit allocator.
`default_nettype none
package cfa_pkg;

  localparam int MEM_UNITS_DEF    = 128;
  localparam int MAX_OWNERS_DEF   = 64;
  localparam int MAX_SEGMENTS_DEF = 130;

  localparam int OWNER_W = 6;
  localparam int SIZE_W  = 8;
  localparam int ADDR_W  = 7;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_NEXT  = 2'd1;
  localparam logic [1:0] POL_BEST  = 2'd2;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NO_FIT   = 2'd1;
  localparam logic [1:0] ST_NO_OWNER = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic               op;
    logic [OWNER_W-1:0] owner_id;
    logic [SIZE_W-1:0]  req_size;
  } in_word_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] start_addr;
    logic [1:0]        status;
  } out_word_t;

endpackage
`default_nettype wire

// ===== rtl/core/cfa_seg_mem.sv =====
// Segment table storage: one write port, one read port, registered read data.
`default_nettype none
module cfa_seg_mem #(
  parameter int DEPTH = cfa_pkg::MAX_SEGMENTS_DEF,
  parameter int WIDTH = 22
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/contiguous_fit_allocator_core.sv =====
// Contiguous fit allocator: segment table sequencer around a one-port-pair memory.
//
//   channel | signals                    | direction | word
//   input   | in_valid, in_stall         | in        | cfa_pkg::in_word_t
//   output  | out_valid, out_stall       | out       | cfa_pkg::out_word_t
//   config  | cfg_wr_en, cfg_wr_data     | in        | fit_policy, 2 bits
//
// One request at a time. Allocate: a scan of the whole table, then each entry
// above the chosen hole is read and shifted up, then the block and the new hole are
// written. Release: scan up to the owner's block, merge it with free neighbours,
// then move each later entry down. All table reads share the single memory read port.
// After reset the INIT state writes the initial hole; input stalls meanwhile.
// A finished result sits in the output register; a new request is taken
// while it waits, and the block holds in its final step only if it is still full.
`default_nettype none
module contiguous_fit_allocator_core #(
  parameter int MEM_UNITS    = cfa_pkg::MEM_UNITS_DEF,
  parameter int MAX_OWNERS   = cfa_pkg::MAX_OWNERS_DEF,
  parameter int MAX_SEGMENTS = cfa_pkg::MAX_SEGMENTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire cfa_pkg::in_word_t  in_word,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      cfa_pkg::out_word_t out_word,
  input  wire logic               cfg_wr_en,
  input  wire logic [1:0]         cfg_wr_data
);

  localparam int SW = $clog2(MEM_UNITS + 1);
  localparam int NW = ((SW > cfa_pkg::SIZE_W) ? SW : cfa_pkg::SIZE_W) + 1;
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  typedef struct packed {
    logic                        taken;
    logic [cfa_pkg::OWNER_W-1:0] owner;
    logic [SW-1:0]               start;
    logic [SW-1:0]               size;
  } seg_t;

  localparam int EW = $bits(seg_t);

  typedef enum logic [3:0] {
    INIT, IDLE, SCAN, DECIDE, SHIFT_RD, SHIFT_WR, WR_BLK, WR_HOLE,
    NEXT_RD, NEXT_GET, REL_CALC, REL_WR, MOVE_RD, MOVE_WR, DONE
  } state_t;

  state_t state;

  logic [1:0]                  policy;
  logic [CW-1:0]               count;
  logic [CW-1:0]               cursor;
  logic                        op;
  logic [cfa_pkg::OWNER_W-1:0] owner;
  logic [cfa_pkg::SIZE_W-1:0]  need;

  logic [CW-1:0] scan_addr;
  logic          rv;
  logic [CW-1:0] rv_idx;

  logic          any_found, cf_found, b_found;
  logic [CW-1:0] any_idx, cf_idx, b_idx;
  logic [SW-1:0] any_start, cf_start, b_start;
  logic [SW-1:0] any_size, cf_size, b_size;
  logic [NW-1:0] b_left;

  logic [CW-1:0] h;
  logic [SW-1:0] hstart, hsize;
  logic [CW-1:0] j;

  seg_t          prev, cur;
  logic [CW-1:0] ri;
  logic          nxt_free;
  logic [SW-1:0] nxt_size;
  logic [CW-1:0] t;
  logic [SW-1:0] tstart, tsize;
  logic [1:0]    k;

  logic [1:0]          res_status;
  logic [SW-1:0]       res_addr;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  seg_t          wseg;
  logic [EW-1:0] rdata;
  seg_t          rseg;

  logic          fits;
  logic [NW-1:0] left;
  logic [CW-1:0] c_eff;
  logic          mp;

  assign rseg  = seg_t'(rdata);
  assign fits  = !rseg.taken && (NW'(rseg.size) >= NW'(need));
  assign left  = NW'(rseg.size) - NW'(need);
  assign c_eff = (cursor < count) ? cursor : '0;
  assign mp    = (ri != '0) && !prev.taken;
  assign in_stall = (state != IDLE);

  cfa_seg_mem #(
    .DEPTH (MAX_SEGMENTS),
    .WIDTH (EW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wseg),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    raddr = '0;
    wseg  = '0;
    unique case (state)
      INIT: begin
        we        = 1'b1;
        wseg.size = SW'(MEM_UNITS);
      end
      SCAN:     raddr = scan_addr[IW-1:0];
      SHIFT_RD: raddr = IW'(j - 1'b1);
      SHIFT_WR: begin
        we    = 1'b1;
        waddr = j[IW-1:0];
        wseg  = rseg;
      end
      WR_BLK: begin
        we    = 1'b1;
        waddr = h[IW-1:0];
        wseg  = '{taken: 1'b1, owner: owner, start: hstart, size: SW'(need)};
      end
      WR_HOLE: begin
        we    = 1'b1;
        waddr = IW'(h + 1'b1);
        wseg  = '{taken: 1'b0, owner: '0, start: hstart + SW'(need),
                  size: hsize - SW'(need)};
      end
      NEXT_RD: raddr = IW'(ri + 1'b1);
      REL_WR: begin
        we    = 1'b1;
        waddr = t[IW-1:0];
        wseg  = '{taken: 1'b0, owner: '0, start: tstart, size: tsize};
      end
      MOVE_RD: raddr = j[IW-1:0];
      MOVE_WR: begin
        we    = 1'b1;
        waddr = IW'(j - CW'(k));
        wseg  = rseg;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= INIT;
      policy    <= cfa_pkg::POL_FIRST;
      count     <= CW'(1);
      cursor    <= '0;
      out_valid <= 1'b0;
      rv        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        policy <= cfg_wr_data;
      end
      if (out_valid && !out_stall && state != DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        INIT: state <= IDLE;
        IDLE: begin
          if (in_valid) begin
            op         <= in_word.op;
            owner      <= in_word.owner_id;
            need       <= in_word.req_size;
            scan_addr  <= '0;
            rv         <= 1'b0;
            any_found  <= 1'b0;
            cf_found   <= 1'b0;
            b_found    <= 1'b0;
            res_addr   <= '0;
            if (in_word.op == cfa_pkg::OP_ALLOC && 32'(in_word.owner_id) >= MAX_OWNERS) begin
              res_status <= cfa_pkg::ST_NO_OWNER;
              state      <= DONE;
            end else begin
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          if (rv && op == cfa_pkg::OP_RELEASE && rseg.taken && rseg.owner == owner) begin
            cur      <= rseg;
            ri       <= rv_idx;
            nxt_free <= 1'b0;
            rv       <= 1'b0;
            state    <= (CW'(rv_idx + 1'b1) < count) ? NEXT_RD : REL_CALC;
          end else begin
            if (scan_addr < count) begin
              scan_addr <= scan_addr + 1'b1;
              rv        <= 1'b1;
              rv_idx    <= scan_addr;
            end else begin
              rv <= 1'b0;
            end
            if (rv) begin
              prev <= rseg;
              if (fits && !any_found) begin
                any_found <= 1'b1;
                any_idx   <= rv_idx;
                any_start <= rseg.start;
                any_size  <= rseg.size;
              end
              if (fits && !cf_found && rv_idx >= c_eff) begin
                cf_found <= 1'b1;
                cf_idx   <= rv_idx;
                cf_start <= rseg.start;
                cf_size  <= rseg.size;
              end
              if (fits && (!b_found || left < b_left)) begin
                b_found <= 1'b1;
                b_idx   <= rv_idx;
                b_start <= rseg.start;
                b_size  <= rseg.size;
                b_left  <= left;
              end
            end
            if (!rv && scan_addr >= count) begin
              if (op == cfa_pkg::OP_ALLOC) begin
                state <= DECIDE;
              end else begin
                res_status <= cfa_pkg::ST_NO_OWNER;
                state      <= DONE;
              end
            end
          end
        end
        DECIDE: begin
          j <= count;
          if (policy == cfa_pkg::POL_NEXT && cf_found) begin
            h <= cf_idx; hstart <= cf_start; hsize <= cf_size;
          end else if (policy == cfa_pkg::POL_BEST) begin
            h <= b_idx; hstart <= b_start; hsize <= b_size;
          end else begin
            h <= any_idx; hstart <= any_start; hsize <= any_size;
          end
          if (policy == cfa_pkg::POL_BEST ? !b_found : !any_found) begin
            res_status <= cfa_pkg::ST_NO_FIT;
            state      <= DONE;
          end else if (32'(count) >= MAX_SEGMENTS) begin
            res_status <= cfa_pkg::ST_FULL;
            state      <= DONE;
          end else begin
            state <= SHIFT_RD;
          end
        end
        SHIFT_RD: state <= (j > h) ? SHIFT_WR : WR_BLK;
        SHIFT_WR: begin
          j     <= j - 1'b1;
          state <= SHIFT_RD;
        end
        WR_BLK: state <= WR_HOLE;
        WR_HOLE: begin
          count      <= count + 1'b1;
          cursor     <= h;
          res_status <= cfa_pkg::ST_DONE;
          res_addr   <= hstart;
          state      <= DONE;
        end
        NEXT_RD: state <= NEXT_GET;
        NEXT_GET: begin
          nxt_free <= !rseg.taken;
          nxt_size <= rseg.size;
          state    <= REL_CALC;
        end
        REL_CALC: begin
          t      <= mp ? ri - 1'b1 : ri;
          tstart <= mp ? prev.start : cur.start;
          tsize  <= cur.size + (mp ? prev.size : '0) + (nxt_free ? nxt_size : '0);
          k      <= 2'(mp) + 2'(nxt_free);
          state  <= REL_WR;
        end
        REL_WR: begin
          j     <= t + 1'b1 + CW'(k);
          state <= MOVE_RD;
        end
        MOVE_RD: begin
          if (j < count) begin
            state <= MOVE_WR;
          end else begin
            count      <= count - CW'(k);
            cursor     <= t;
            res_status <= cfa_pkg::ST_DONE;
            state      <= DONE;
          end
        end
        MOVE_WR: begin
          j     <= j + 1'b1;
          state <= MOVE_RD;
        end
        DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid           <= 1'b1;
            out_word.ok         <= (res_status == cfa_pkg::ST_DONE);
            out_word.start_addr <= cfa_pkg::ADDR_W'(res_addr);
            out_word.status     <= res_status;
            state               <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count >= CW'(1)) && (32'(count) <= MAX_SEGMENTS))
    else $error("segment count out of range");

  a_write_in_table: assert property (@(posedge clk) disable iff (rst)
    we |-> (32'(waddr) <= 32'(count)) && (32'(waddr) < MAX_SEGMENTS))
    else $error("table write beyond live entries");

  a_ok_matches_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.ok == (out_word.status == cfa_pkg::ST_DONE)))
    else $error("ok flag disagrees with status");

  a_fail_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_word.ok) |-> (out_word.start_addr == '0))
    else $error("failed request reports an address");

  a_count_moves_on_finish: assert property (@(posedge clk) disable iff (rst)
    (state != WR_HOLE && state != MOVE_RD) |=> $stable(count))
    else $error("segment count changed outside commit");
`endif

endmodule
`default_nettype wire

// ===== test/tb_contiguous_fit_allocator_core.sv =====
// Self-checking testbench for the contiguous fit allocator core.
`default_nettype none
module tb_contiguous_fit_allocator_core;

  localparam int MEM  = 128;
  localparam int NSEG = 130;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  cfa_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  cfa_pkg::out_word_t out_word;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_wr_data = '0;

  contiguous_fit_allocator_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // predictor copy of the segment table
  typedef struct {
    bit taken;
    int unsigned owner;
    int unsigned start;
    int unsigned size;
  } seg_t;

  seg_t segs[NSEG];
  int unsigned seg_cnt;
  int unsigned cursor;
  logic [1:0] policy;

  cfa_pkg::in_word_t  pending_words[$];
  cfa_pkg::out_word_t expected_words[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_cycles = 0;
  bit hold_req = 0;

  function automatic void table_reset();
    foreach (segs[i]) segs[i] = '{0, 0, 0, 0};
    segs[0].size = MEM;
    seg_cnt = 1;
    cursor = 0;
  endfunction

  function automatic bit fits(int unsigned i, int unsigned need);
    return !segs[i].taken && segs[i].size >= need;
  endfunction

  function automatic int find_hole(int unsigned need);
    int best;
    int unsigned least, c;
    best = -1;
    least = 0;
    if (policy == cfa_pkg::POL_NEXT) begin
      c = (cursor < seg_cnt) ? cursor : 0;
      for (int unsigned i = c; i < seg_cnt; i++) if (fits(i, need)) return int'(i);
      for (int unsigned i = 0; i < c; i++) if (fits(i, need)) return int'(i);
      return -1;
    end
    if (policy == cfa_pkg::POL_BEST) begin
      for (int unsigned i = 0; i < seg_cnt; i++)
        if (fits(i, need) && (best < 0 || segs[i].size - need < least)) begin
          least = segs[i].size - need;
          best = int'(i);
        end
      return best;
    end
    for (int unsigned i = 0; i < seg_cnt; i++) if (fits(i, need)) return int'(i);
    return -1;
  endfunction

  function automatic void drop_entry(int unsigned k);
    for (int unsigned j = k; j + 1 < seg_cnt; j++) segs[j] = segs[j+1];
    seg_cnt--;
  endfunction

  function automatic cfa_pkg::out_word_t predict_alloc(cfa_pkg::in_word_t w);
    cfa_pkg::out_word_t r;
    int f;
    int unsigned h, i, need;
    r = '0;
    r.status = cfa_pkg::ST_DONE;
    need = w.req_size;
    if (w.op == cfa_pkg::OP_ALLOC) begin
      f = find_hole(need);
      if (f < 0) r.status = cfa_pkg::ST_NO_FIT;
      else if (seg_cnt >= NSEG) r.status = cfa_pkg::ST_FULL;
      else begin
        h = f;
        for (int unsigned j = seg_cnt; j > h; j--) segs[j] = segs[j-1];
        segs[h].taken = 1;
        segs[h].owner = w.owner_id;
        segs[h].size = need;
        segs[h+1].start += need;
        segs[h+1].size -= need;
        seg_cnt++;
        cursor = h;
        r.start_addr = segs[h].start[cfa_pkg::ADDR_W-1:0];
      end
    end else begin
      for (i = 0; i < seg_cnt; i++)
        if (segs[i].taken && segs[i].owner == w.owner_id) break;
      if (i >= seg_cnt) r.status = cfa_pkg::ST_NO_OWNER;
      else begin
        segs[i].taken = 0;
        segs[i].owner = 0;
        if (i + 1 < seg_cnt && !segs[i+1].taken) begin
          segs[i].size += segs[i+1].size;
          drop_entry(i + 1);
        end
        if (i > 0 && !segs[i-1].taken) begin
          segs[i-1].size += segs[i].size;
          drop_entry(i);
          i--;
        end
        cursor = i;
      end
    end
    r.ok = (r.status == cfa_pkg::ST_DONE);
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_words.push_back(predict_alloc(in_word));
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_word <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    cfa_pkg::out_word_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word %p", $time, out_word);
          errors++;
        end else begin
          e = expected_words.pop_front();
          if (out_word.ok !== e.ok || out_word.start_addr !== e.start_addr ||
              out_word.status !== e.status) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, out_word);
            errors++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 0;
        hold_cycles = 3000;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  function automatic cfa_pkg::in_word_t mk(logic op, int unsigned own, int unsigned sz);
    cfa_pkg::in_word_t w;
    w.op = op;
    w.owner_id = cfa_pkg::OWNER_W'(own);
    w.req_size = cfa_pkg::SIZE_W'(sz);
    return w;
  endfunction

  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (800) @(posedge clk);
  endtask

  task automatic set_policy(logic [1:0] p);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= p;
    policy = p;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic add_random(int n);
    int unsigned k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 50)
        pending_words.push_back(mk(cfa_pkg::OP_ALLOC, $urandom_range(63),
                                   ($urandom_range(9) == 0) ? $urandom_range(255)
                                                             : $urandom_range(12)));
      else if (k < 90)
        pending_words.push_back(mk(cfa_pkg::OP_RELEASE, $urandom_range(63), 0));
      else
        pending_words.push_back(mk(1'($urandom_range(1)), $urandom_range(63),
                                   $urandom_range(255)));
    end
  endtask

  initial begin
    table_reset();
    policy = cfa_pkg::POL_FIRST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes, zero size, duplicate owners, unknown owner
    pending_words.push_back(mk(cfa_pkg::OP_ALLOC, 0, 0));
    pending_words.push_back(mk(cfa_pkg::OP_ALLOC, 63, 129));
    pending_words.push_back(mk(cfa_pkg::OP_ALLOC, 63, 255));
    pending_words.push_back(mk(cfa_pkg::OP_ALLOC, 5, 10));
    pending_words.push_back(mk(cfa_pkg::OP_ALLOC, 5, 20));
    pending_words.push_back(mk(cfa_pkg::OP_ALLOC, 7, 30));
    pending_words.push_back(mk(cfa_pkg::OP_RELEASE, 5, 0));
    pending_words.push_back(mk(cfa_pkg::OP_RELEASE, 9, 255));
    pending_words.push_back(mk(cfa_pkg::OP_RELEASE, 5, 0));
    pending_words.push_back(mk(cfa_pkg::OP_RELEASE, 7, 0));
    pending_words.push_back(mk(cfa_pkg::OP_RELEASE, 0, 0));
    pending_words.push_back(mk(cfa_pkg::OP_ALLOC, 1, 128));
    pending_words.push_back(mk(cfa_pkg::OP_ALLOC, 2, 0));
    pending_words.push_back(mk(cfa_pkg::OP_RELEASE, 1, 0));
    pending_words.push_back(mk(cfa_pkg::OP_RELEASE, 2, 0));
    drain();
    // best fit then next fit
    for (int p = cfa_pkg::POL_BEST; p >= cfa_pkg::POL_NEXT; p--) begin
      set_policy(2'(p));
      for (int i = 0; i < 4; i++)
        pending_words.push_back(mk(cfa_pkg::OP_ALLOC, i, 8 * (i + 1)));
      pending_words.push_back(mk(cfa_pkg::OP_RELEASE, 1, 0));
      pending_words.push_back(mk(cfa_pkg::OP_ALLOC, 10, 12));
      pending_words.push_back(mk(cfa_pkg::OP_ALLOC, 11, 5));
      for (int i = 0; i < 64; i++) pending_words.push_back(mk(cfa_pkg::OP_RELEASE, i, 0));
      drain();
    end
    // fill the table with zero-size blocks, then hit table full
    set_policy(cfa_pkg::POL_FIRST);
    for (int i = 0; i < 132; i++) pending_words.push_back(mk(cfa_pkg::OP_ALLOC, i % 64, 0));
    hold_req = 1;
    drain();
    for (int i = 0; i < 140; i++) pending_words.push_back(mk(cfa_pkg::OP_RELEASE, i % 64, 0));
    drain();
    send_idle = 25;
    recv_idle = 78;
    for (int ph = 0; ph < 4; ph++) begin
      set_policy(2'(ph));
      if (ph == 2) begin
        send_idle = 78;
        recv_idle = 25;
      end
      if (ph == 3) begin
        send_idle = 0;
        recv_idle = 0;
      end
      add_random(345);
      drain();
    end
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #300000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire
